// File: rtl/string_heredoc_comment_scanner_defines.svh
// assertion macros for the string, heredoc and comment scanner
// used by the files that carry concurrent checks; needs clk_i and rst_ni in scope
`ifndef STRING_HEREDOC_COMMENT_SCANNER_DEFINES_SVH
`define STRING_HEREDOC_COMMENT_SCANNER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define SHDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define SHDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SHDC_ASSERT(lbl, prop, msg)
`define SHDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/shdc_pkg.sv
// shared types and codes for the string, heredoc and comment scanner
// no dependencies
package shdc_pkg;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_EOI   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_UNTERM   = 3'd1;
  localparam logic [2:0] ST_BAD_OPEN = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NONE_OK  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [1:0] TOK_TRIPLE  = 2'd0;
  localparam logic [1:0] TOK_HEREDOC = 2'd1;
  localparam logic [1:0] TOK_COMMENT = 2'd2;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SELECT  = 4'd1;
  localparam logic [3:0] PH_T_BODY  = 4'd2;
  localparam logic [3:0] PH_H_DASH  = 4'd3;
  localparam logic [3:0] PH_H_BLANK = 4'd4;
  localparam logic [3:0] PH_H_BODY  = 4'd5;
  localparam logic [3:0] PH_H_RUN   = 4'd6;
  localparam logic [3:0] PH_C_OPEN  = 4'd7;
  localparam logic [3:0] PH_C_BODY  = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;

  localparam logic [1:0] PREV_NONE  = 2'd0;
  localparam logic [1:0] PREV_SLASH = 2'd1;
  localparam logic [1:0] PREV_STAR  = 2'd2;

  // allow flag bit positions
  localparam int ALLOW_TRIPLE  = 0;
  localparam int ALLOW_HEREDOC = 1;
  localparam int ALLOW_COMMENT = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] allow;
    logic [1:0] quote_run;
    logic       escape;
    logic       text_seen;
    logic [1:0] prev;
  } shdc_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  token_kind;
    logic [15:0] token_length;
  } shdc_result_t;

  function automatic logic [1:0] kind_of_phase(input logic [3:0] ph);
    logic [1:0] k;
    k = TOK_TRIPLE;
    if (ph inside {PH_H_DASH, PH_H_BLANK, PH_H_BODY, PH_H_RUN}) k = TOK_HEREDOC;
    else if (ph inside {PH_C_OPEN, PH_C_BODY}) k = TOK_COMMENT;
    return k;
  endfunction

endpackage

// File: rtl/string_heredoc_comment_scanner.sv
// Scanner for triple-quoted string content, heredoc content and nested block
// comments, one character transaction per clock unless the input is stalled. A
// transaction is captured in an input register, the scan state is updated from
// it and any result lands in an output register, so a result passes through
// both registers after its transaction is taken. The sustained rate is one
// transaction per cycle while the output side keeps up; input stalls only while a
// transaction waits behind a result that the output side has not yet taken.
// depends on shdc_pkg, shdc_step and string_heredoc_comment_scanner_defines.svh
`include "string_heredoc_comment_scanner_defines.svh"
module string_heredoc_comment_scanner #(
  parameter longint unsigned MAX_LENGTH = 65535,
  parameter int unsigned     MAX_DEPTH  = 255,
  parameter int unsigned     MAX_DASHES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic        allow_comment_i,
  input  logic        allow_triple_i,
  input  logic        allow_heredoc_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  token_kind_o,
  output logic [15:0] token_length_o
);
  import shdc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_LENGTH + 64'd1);
  localparam int DEP_W  = $clog2(MAX_DEPTH + 1);
  localparam int DASH_W = $clog2(MAX_DASHES + 1);

  logic              s1_valid_q, s1_valid_d;
  logic [1:0]        s1_kind_q;
  logic              s1_ac_q, s1_at_q, s1_ah_q;
  logic [7:0]        s1_ch_q;

  shdc_state_t       st_q, st_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  mark_q, mark_d;
  logic [DASH_W-1:0] dtarget_q, dtarget_d;
  logic [DASH_W-1:0] drun_q, drun_d;
  logic [DEP_W-1:0]  depth_q, depth_d;

  logic              out_valid_q, out_valid_d;
  shdc_result_t      res_q, res_d;

  logic              emit;
  logic              out_free;
  logic              advance;
  logic              in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  shdc_step #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_DEPTH  (MAX_DEPTH),
    .MAX_DASHES (MAX_DASHES)
  ) u_step (
    .kind_i          (s1_kind_q),
    .allow_comment_i (s1_ac_q),
    .allow_triple_i  (s1_at_q),
    .allow_heredoc_i (s1_ah_q),
    .ch_i            (s1_ch_q),
    .st_i            (st_q),
    .cnt_i           (cnt_q),
    .mark_i          (mark_q),
    .dtarget_i       (dtarget_q),
    .drun_i          (drun_q),
    .depth_i         (depth_q),
    .st_o            (st_d),
    .cnt_o           (cnt_d),
    .mark_o          (mark_d),
    .dtarget_o       (dtarget_d),
    .drun_o          (drun_d),
    .depth_o         (depth_d),
    .emit_o          (emit),
    .res_o           (res_d)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance && emit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_IDLE, allow: 3'd0, quote_run: 2'd0, escape: 1'b0,
                       text_seen: 1'b0, prev: PREV_NONE};
      cnt_q       <= '0;
      mark_q      <= '0;
      dtarget_q   <= DASH_W'(3);
      drun_q      <= '0;
      depth_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        st_q      <= st_d;
        cnt_q     <= cnt_d;
        mark_q    <= mark_d;
        dtarget_q <= dtarget_d;
        drun_q    <= drun_d;
        depth_q   <= depth_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_i;
      s1_ac_q   <= allow_comment_i;
      s1_at_q   <= allow_triple_i;
      s1_ah_q   <= allow_heredoc_i;
      s1_ch_q   <= ch_i;
    end
    if (advance && emit) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign token_kind_o   = res_q.token_kind;
  assign token_length_o = res_q.token_length;

  `SHDC_ASSERT_ALWAYS(a_stall_needs_item, in_stall_o |-> s1_valid_q,
                      "stall without held transaction")
  `SHDC_ASSERT(a_done_after_result, (advance && emit) |=> (st_q.phase == PH_DONE),
               "scan not closed after result")
  `SHDC_ASSERT(a_len_only_when_marked,
               (out_valid_q && res_q.status != ST_ACCEPTED && res_q.status != ST_EMPTY)
               |-> (res_q.token_length == 16'd0),
               "length on unmarked status")
  `SHDC_ASSERT(a_depth_in_comment,
               (depth_q != '0) |-> (st_q.phase == PH_C_BODY || st_q.phase == PH_DONE),
               "nesting depth outside comment")

endmodule

// File: rtl/shdc_step.sv
// next-state and result logic for one transaction of the scanner
// depends on shdc_pkg
module shdc_step #(
  parameter longint unsigned MAX_LENGTH = 65535,
  parameter int unsigned     MAX_DEPTH  = 255,
  parameter int unsigned     MAX_DASHES = 255,
  localparam int CNT_W  = $clog2(MAX_LENGTH + 64'd1),
  localparam int DEP_W  = $clog2(MAX_DEPTH + 1),
  localparam int DASH_W = $clog2(MAX_DASHES + 1)
) (
  input  logic [1:0]           kind_i,
  input  logic                 allow_comment_i,
  input  logic                 allow_triple_i,
  input  logic                 allow_heredoc_i,
  input  logic [7:0]           ch_i,
  input  shdc_pkg::shdc_state_t st_i,
  input  logic [CNT_W-1:0]     cnt_i,
  input  logic [CNT_W-1:0]     mark_i,
  input  logic [DASH_W-1:0]    dtarget_i,
  input  logic [DASH_W-1:0]    drun_i,
  input  logic [DEP_W-1:0]     depth_i,
  output shdc_pkg::shdc_state_t st_o,
  output logic [CNT_W-1:0]     cnt_o,
  output logic [CNT_W-1:0]     mark_o,
  output logic [DASH_W-1:0]    dtarget_o,
  output logic [DASH_W-1:0]    drun_o,
  output logic [DEP_W-1:0]     depth_o,
  output logic                 emit_o,
  output shdc_pkg::shdc_result_t res_o
);
  import shdc_pkg::*;

  localparam int EXT_W = (CNT_W > 16) ? CNT_W : 16;

  logic [3:0]       ph;
  logic             go;
  logic             done;
  logic             hit;
  logic [2:0]       r_status;
  logic [1:0]       r_kind;
  logic [CNT_W-1:0] pos;
  logic [EXT_W-1:0] mark_ext;

  always_comb begin
    st_o      = st_i;
    cnt_o     = cnt_i;
    mark_o    = mark_i;
    dtarget_o = dtarget_i;
    drun_o    = drun_i;
    depth_o   = depth_i;
    ph        = st_i.phase;
    go        = 1'b0;
    done      = 1'b0;
    hit       = 1'b0;
    r_status  = ST_ACCEPTED;
    r_kind    = TOK_TRIPLE;
    pos       = cnt_i;

    if (kind_i == KIND_BEGIN) begin
      st_o.phase       = PH_SELECT;
      st_o.allow       = {allow_comment_i, allow_heredoc_i, allow_triple_i};
      st_o.quote_run   = 2'd0;
      st_o.escape      = 1'b0;
      st_o.text_seen   = 1'b0;
      st_o.prev        = PREV_NONE;
      cnt_o            = '0;
      mark_o           = '0;
      dtarget_o        = DASH_W'(3);
      drun_o           = '0;
      depth_o          = '0;
    end else if (st_i.phase == PH_IDLE || st_i.phase == PH_DONE || kind_i == KIND_NONE) begin
      // ignored
    end else if (kind_i == KIND_EOI) begin
      hit      = 1'b1;
      r_status = ST_UNTERM;
      if (st_i.phase == PH_SELECT) begin
        if (st_i.allow[ALLOW_TRIPLE]) r_kind = TOK_TRIPLE;
        else if (st_i.allow[ALLOW_HEREDOC]) r_kind = TOK_HEREDOC;
        else r_status = ST_NONE_OK;
      end else begin
        r_kind = kind_of_phase(st_i.phase);
      end
    end else begin
      go = 1'b1;
      if (st_i.phase == PH_SELECT) begin
        if (st_i.allow[ALLOW_COMMENT] && ch_i == CH_SLASH) begin
          // the opening slash is counted but not scanned
          st_o.phase = PH_C_OPEN;
          cnt_o      = CNT_W'(1);
          go         = 1'b0;
        end else if (st_i.allow[ALLOW_TRIPLE]) begin
          ph = PH_T_BODY;
        end else if (st_i.allow[ALLOW_HEREDOC]) begin
          ph = PH_H_DASH;
        end else begin
          hit      = 1'b1;
          r_status = ST_NONE_OK;
          go       = 1'b0;
        end
      end

      if (go) begin
        if (cnt_i >= CNT_W'(MAX_LENGTH)) begin
          hit      = 1'b1;
          r_status = ST_OVERFLOW;
        end else begin
          cnt_o = cnt_i + CNT_W'(1);
          if (ph == PH_T_BODY) begin
            if (st_i.escape) begin
              st_o.escape = 1'b0;
            end else if (ch_i == CH_QUOTE) begin
              if (st_i.quote_run == 2'd0) begin
                mark_o         = pos;
                st_o.quote_run = 2'd1;
              end else if (st_i.quote_run == 2'd1) begin
                st_o.quote_run = 2'd2;
              end else begin
                hit      = 1'b1;
                r_status = st_i.text_seen ? ST_ACCEPTED : ST_EMPTY;
              end
            end else begin
              st_o.quote_run = 2'd0;
              st_o.text_seen = 1'b1;
              if (ch_i == CH_BSLASH) st_o.escape = 1'b1;
            end
          end else if (ph == PH_C_OPEN || ph == PH_C_BODY) begin
            if (ph == PH_C_OPEN) begin
              if (ch_i != CH_STAR) begin
                hit      = 1'b1;
                r_status = ST_BAD_OPEN;
              end else begin
                depth_o   = DEP_W'(1);
                st_o.prev = PREV_NONE;
                ph        = PH_C_BODY;
              end
            end else if (st_i.prev == PREV_SLASH && ch_i == CH_STAR) begin
              st_o.prev = PREV_NONE;
              if (depth_i >= DEP_W'(MAX_DEPTH)) begin
                hit      = 1'b1;
                r_status = ST_OVERFLOW;
              end else begin
                depth_o = depth_i + DEP_W'(1);
              end
            end else if (st_i.prev == PREV_STAR && ch_i == CH_SLASH) begin
              st_o.prev = PREV_NONE;
              if (depth_i != '0) depth_o = depth_i - DEP_W'(1);
              if (depth_o == '0) begin
                mark_o = pos + CNT_W'(1);
                hit    = 1'b1;
              end
            end else begin
              st_o.prev = (ch_i == CH_SLASH) ? PREV_SLASH :
                          ((ch_i == CH_STAR) ? PREV_STAR : PREV_NONE);
            end
          end else begin
            // heredoc: opening dashes, blanks, newline, body, closing run
            if (ph == PH_H_DASH) begin
              if (ch_i == CH_DASH) begin
                done = 1'b1;
                if (dtarget_i >= DASH_W'(MAX_DASHES)) begin
                  hit      = 1'b1;
                  r_status = ST_OVERFLOW;
                end else begin
                  dtarget_o = dtarget_i + DASH_W'(1);
                end
              end else begin
                ph = PH_H_BLANK;
              end
            end
            if (!done && ph == PH_H_BLANK) begin
              done = 1'b1;
              if (ch_i == CH_NL) begin
                ph = PH_H_BODY;
              end else if (!(ch_i inside {CH_SPACE, CH_TAB})) begin
                hit      = 1'b1;
                r_status = ST_BAD_OPEN;
              end
            end
            if (!done && ph == PH_H_RUN) begin
              done = 1'b1;
              if (ch_i == CH_DASH) begin
                drun_o = drun_i + DASH_W'(1);
                if (drun_o >= dtarget_i) hit = 1'b1;
              end else begin
                ph = PH_H_BODY;
              end
            end
            if (!done && ch_i == CH_DASH) begin
              mark_o = pos;
              drun_o = DASH_W'(1);
              if (drun_o >= dtarget_o) hit = 1'b1;
              else ph = PH_H_RUN;
            end
          end
        end
        r_kind     = kind_of_phase(ph);
        st_o.phase = ph;
      end
    end

    if (hit) st_o.phase = PH_DONE;
  end

  assign mark_ext = EXT_W'(mark_o);

  assign emit_o             = hit;
  assign res_o.status       = r_status;
  assign res_o.token_kind   = r_kind;
  assign res_o.token_length = (r_status == ST_ACCEPTED || r_status == ST_EMPTY) ?
                              mark_ext[15:0] : 16'd0;

endmodule
